[design/gfepa_pkg.sv]
// Shared types, constants and the GF(2^8) multiply for the erasure parity accumulator.
`default_nettype none

package gfepa_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned BYTE_LANES     = 4;
  localparam int unsigned WORD_W         = BYTE_W * BYTE_LANES;
  localparam int unsigned LANE_CNT_W     = 3;
  localparam int unsigned LANES_DEFAULT  = 4;
  localparam int unsigned IN_TDATA_W     = 48;
  localparam logic [BYTE_W-1:0] FIELD_POLY_RESET = 8'h1D;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic                  first_term;
    logic                  last_term;
    logic [LANE_CNT_W-1:0] lane_count;
  } term_ctrl_t;

  // Shift-and-reduce carry-less product modulo x^8 + poly.
  function automatic byte_t gf_mul(input byte_t a, input byte_t b, input byte_t poly);
    byte_t prod;
    byte_t x;
    prod = '0;
    x    = a;
    for (int bit_idx = 0; bit_idx < BYTE_W; bit_idx++) begin
      if (b[bit_idx]) begin
        prod = prod ^ x;
      end
      if (x[BYTE_W-1]) begin
        x = {x[BYTE_W-2:0], 1'b0} ^ poly;
      end else begin
        x = {x[BYTE_W-2:0], 1'b0};
      end
    end
    return prod;
  endfunction

endpackage

`default_nettype wire

[design/gfepa_lane.sv]
// One byte lane: GF(2^8) product of a source byte and the block coefficient.
`default_nettype none

module gfepa_lane (
  input  gfepa_pkg::byte_t src_byte_i,
  input  gfepa_pkg::byte_t coef_i,
  input  gfepa_pkg::byte_t poly_i,
  input  logic             lane_en_i,
  output gfepa_pkg::byte_t product_o
);
  import gfepa_pkg::*;

  byte_t product;

  always_comb begin
    product = gf_mul(src_byte_i, coef_i, poly_i);
  end

  // drop the product of a lane beyond the valid count
  assign product_o = lane_en_i ? product : '0;

endmodule

`default_nettype wire

[design/gfepa_merge.sv]
// Merge stage: accumulates the lane products and queues parity words for output.
`default_nettype none

module gfepa_merge #(
  parameter int unsigned LANES = gfepa_pkg::LANES_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  gfepa_pkg::word_t      term_i,
  input  gfepa_pkg::term_ctrl_t ctrl_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output gfepa_pkg::word_t      out_data_o
);
  import gfepa_pkg::*;

  localparam int unsigned ActLanes = (LANES < BYTE_LANES) ? LANES : BYTE_LANES;

  word_t acc_q, acc_d;
  word_t mask;
  word_t result;
  word_t head_q, head_d;
  word_t skid_q, skid_d;
  logic  head_valid_q, head_valid_d;
  logic  skid_valid_q, skid_valid_d;
  logic  push, pop;

  always_comb begin
    mask = '0;
    for (int i = 0; i < BYTE_LANES; i++) begin
      if ((i < ActLanes) && (ctrl_i.lane_count > LANE_CNT_W'(i))) begin
        mask[i*BYTE_W +: BYTE_W] = '1;
      end
    end
  end

  assign acc_d  = (ctrl_i.first_term ? '0 : acc_q) ^ term_i;
  assign result = acc_d & mask;
  assign push   = accept_i && ctrl_i.last_term;
  assign pop    = head_valid_q && out_ready_i;

  always_comb begin
    head_d       = head_q;
    skid_d       = skid_q;
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      if (skid_valid_q) begin
        // advance the skid entry into the head
        head_d       = skid_q;
        skid_valid_d = push;
        skid_d       = result;
      end else begin
        head_valid_d = push;
        head_d       = result;
      end
    end else if (push) begin
      if (!head_valid_q) begin
        head_valid_d = 1'b1;
        head_d       = result;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = result;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        acc_q <= acc_d;
      end
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = head_valid_q;
  assign out_data_o  = head_q;

  a_skid_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> head_valid_q)
    else $error("skid entry held without a head entry");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> !skid_valid_q)
    else $error("request accepted while the output queue is full");

  a_skid_refills_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && skid_valid_q) |=> (head_valid_q && head_q == $past(skid_q)))
    else $error("skid entry lost on output transfer");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !head_valid_q) |=> (head_valid_q && head_q == $past(result)))
    else $error("parity word not captured into an empty queue");

endmodule

`default_nettype wire

[design/gf256_erasure_parity_accumulator.sv]
// Top level of the GF(2^8) erasure parity accumulator.
// Usage:
//   s_axis: one request per source block word. tdata carries the four source
//   bytes, the matrix coefficient and the valid lane count; tuser marks the
//   first term of a combination (clears the accumulator), tlast the last
//   term (emits the parity word after adding this term).
//   m_axis: one parity word per tlast request, bytes at or beyond the lane
//   count of that request read as zero.
//   cfg: write of the low eight bits of the field polynomial (x^8 implied);
//   write only while no request is in flight.
// Throughput is one request per cycle while s_axis_tready is high: each byte
// lane has its own GF(2^8) multiplier and the accumulate is a single XOR
// into a register. Parity words are registered in the output queue.
// When the receiver stalls, a second parity word is held in a skid entry;
// s_axis_tready drops only when both output entries are full.
// Reset clears the accumulator and the output queue and sets the polynomial
// to 0x11D.
`default_nettype none

module gf256_erasure_parity_accumulator #(
  parameter int unsigned LANES = gfepa_pkg::LANES_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // source bytes [31:0], coefficient [39:32], lane count [42:40], zero fill
  input  logic [gfepa_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // first term [0]
  input  logic                             s_axis_tuser,
  input  logic                             s_axis_tlast,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // parity bytes [31:0]
  output gfepa_pkg::word_t                 m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  gfepa_pkg::byte_t                 cfg_data_i
);
  import gfepa_pkg::*;

  localparam int unsigned ActLanes = (LANES < BYTE_LANES) ? LANES : BYTE_LANES;

  byte_t      field_poly_q;
  word_t      src_word;
  byte_t      coef;
  word_t      term;
  term_ctrl_t ctrl;
  logic       accept;
  logic       in_ready;

  assign src_word        = s_axis_tdata[WORD_W-1:0];
  assign coef            = s_axis_tdata[WORD_W +: BYTE_W];
  assign ctrl.lane_count = s_axis_tdata[WORD_W+BYTE_W +: LANE_CNT_W];
  assign ctrl.first_term = s_axis_tuser;
  assign ctrl.last_term  = s_axis_tlast;

  assign accept        = s_axis_tvalid && in_ready;
  assign s_axis_tready = in_ready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_poly_q <= FIELD_POLY_RESET;
    end else if (cfg_valid_i) begin
      field_poly_q <= cfg_data_i;
    end
  end

  for (genvar i = 0; i < BYTE_LANES; i++) begin : g_lane
    if (i < ActLanes) begin : g_active
      gfepa_lane u_lane (
        .src_byte_i (src_word[i*BYTE_W +: BYTE_W]),
        .coef_i     (coef),
        .poly_i     (field_poly_q),
        .lane_en_i  (ctrl.lane_count > LANE_CNT_W'(i)),
        .product_o  (term[i*BYTE_W +: BYTE_W])
      );
    end else begin : g_unused
      assign term[i*BYTE_W +: BYTE_W] = '0;
    end
  end

  gfepa_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .term_i      (term),
    .ctrl_i      (ctrl),
    .in_ready_o  (in_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
